// ----- rtl/fcfsrq_pkg.sv -----
`timescale 1ns / 1ps

package fcfsrq_pkg;

    // Default sizes
    localparam int RUN_DEPTH_DEF    = 16;
    localparam int ZOMBIE_DEPTH_DEF = 8;
    localparam int CPU_BITS_DEF     = 4;
    localparam int ID_BITS_DEF      = 8;

    // Fixed field widths of the result channel
    localparam int MODE_W   = 3;
    localparam int KIND_W   = 2;
    localparam int OUT_ID_W = 8;
    localparam int QCNT_W   = 5;

    // Descriptor flag bits, low end of a packed descriptor {id, cpu, flags}
    localparam int DESC_FLAG_W = 4;
    localparam int DESC_READY  = 3;
    localparam int DESC_IDLE   = 2;
    localparam int DESC_INIT   = 1;
    localparam int DESC_HARD   = 0;

    // Match classes kept per cell: three steal levels and the head-first match
    localparam int PICK_W  = 4;
    localparam int UP_W    = 3;
    localparam int PICK_L0 = 0;
    localparam int PICK_L1 = 1;
    localparam int PICK_L2 = 2;
    localparam int PICK_DN = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ    = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_FETCH  = 3'd2,
        MODE_STEAL  = 3'd3,
        MODE_TICK   = 3'd4
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_THREAD  = 2'd1,
        KIND_ZOMBIE  = 2'd2,
        KIND_RESCHED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FIRST,
        ST_APPLY,
        ST_EMIT,
        ST_ZREAD,
        ST_ZEMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_MATCH,
        OP_FIRST,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic                  fetch;
        logic [PICK_W-1:0]     pick;
    } t_cell_ctl;

endpackage

// ----- rtl/fcfsrq_cell.sv -----
`timescale 1ns / 1ps

module fcfsrq_cell #(
    parameter int ID_BITS  = fcfsrq_pkg::ID_BITS_DEF,
    parameter int CPU_BITS = fcfsrq_pkg::CPU_BITS_DEF
) (
    input  logic                                              i_clk,
    input  fcfsrq_pkg::t_cell_ctl                             i_ctl,
    input  logic                                              i_occ,
    input  logic                                              i_wr,
    input  logic [ID_BITS+CPU_BITS+fcfsrq_pkg::DESC_FLAG_W-1:0] i_new_desc,
    input  logic [ID_BITS+CPU_BITS+fcfsrq_pkg::DESC_FLAG_W-1:0] i_next_desc,
    input  logic [ID_BITS-1:0]                                i_key_id,
    input  logic [ID_BITS-1:0]                                i_cur_id,
    input  logic [CPU_BITS-1:0]                               i_cpu,
    input  logic [fcfsrq_pkg::UP_W-1:0]                       i_up_seen,
    input  logic                                              i_dn_seen,
    input  logic                                              i_sel_seen,
    output logic [ID_BITS+CPU_BITS+fcfsrq_pkg::DESC_FLAG_W-1:0] o_desc,
    output logic [fcfsrq_pkg::UP_W-1:0]                       o_up_seen,
    output logic                                              o_dn_seen,
    output logic                                              o_sel_seen,
    output logic                                              o_sel,
    output logic [ID_BITS-1:0]                                o_hit
);

    localparam int DESC_W = ID_BITS + CPU_BITS + fcfsrq_pkg::DESC_FLAG_W;

    logic [DESC_W-1:0]             r_desc;
    logic [fcfsrq_pkg::PICK_W-1:0] r_m;
    logic [fcfsrq_pkg::PICK_W-1:0] r_f;
    logic [fcfsrq_pkg::PICK_W-1:0] n_m;
    logic [fcfsrq_pkg::PICK_W-1:0] n_f;
    logic [ID_BITS-1:0]            w_id;
    logic [CPU_BITS-1:0]           w_cpu;
    logic                          w_elig;
    logic                          w_sel;

    assign w_id  = r_desc[DESC_W-1 -: ID_BITS];
    assign w_cpu = r_desc[CPU_BITS+fcfsrq_pkg::DESC_FLAG_W-1 -: CPU_BITS];

    // Stealable: ready, neither idle nor init, and not the running thread
    assign w_elig = i_occ && r_desc[fcfsrq_pkg::DESC_READY]
                 && !r_desc[fcfsrq_pkg::DESC_IDLE] && !r_desc[fcfsrq_pkg::DESC_INIT]
                 && (w_id != i_cur_id);

    always_comb begin
        n_m = '0;
        n_m[fcfsrq_pkg::PICK_L0] = w_elig && (w_cpu == i_cpu);
        n_m[fcfsrq_pkg::PICK_L1] = w_elig && !r_desc[fcfsrq_pkg::DESC_HARD];
        n_m[fcfsrq_pkg::PICK_L2] = w_elig && r_desc[fcfsrq_pkg::DESC_HARD];
        n_m[fcfsrq_pkg::PICK_DN] = i_occ && (i_ctl.fetch || (w_id == i_key_id));

        // First match seen from the tail for steal levels, from the head otherwise
        n_f = '0;
        n_f[fcfsrq_pkg::UP_W-1:0] = r_m[fcfsrq_pkg::UP_W-1:0] & ~i_up_seen;
        n_f[fcfsrq_pkg::PICK_DN]  = r_m[fcfsrq_pkg::PICK_DN] && !i_dn_seen;
    end

    assign o_up_seen  = i_up_seen | r_m[fcfsrq_pkg::UP_W-1:0];
    assign o_dn_seen  = i_dn_seen | r_m[fcfsrq_pkg::PICK_DN];
    assign w_sel      = |(r_f & i_ctl.pick);
    assign o_sel      = w_sel;
    assign o_sel_seen = i_sel_seen | w_sel;
    assign o_hit      = w_sel ? w_id : '0;
    assign o_desc     = r_desc;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_desc <= i_new_desc;
        end else if (i_ctl.op == fcfsrq_pkg::OP_SHIFT && (i_sel_seen || w_sel)) begin
            r_desc <= i_next_desc;
        end
        if (i_ctl.op == fcfsrq_pkg::OP_MATCH) begin
            r_m <= n_m;
        end
        if (i_ctl.op == fcfsrq_pkg::OP_FIRST) begin
            r_f <= n_f;
        end
    end

endmodule

// ----- rtl/fcfsrq_zq.sv -----
`timescale 1ns / 1ps

module fcfsrq_zq #(
    parameter int ZOMBIE_DEPTH = fcfsrq_pkg::ZOMBIE_DEPTH_DEF,
    parameter int ID_BITS      = fcfsrq_pkg::ID_BITS_DEF,
    localparam int ZA_W        = (ZOMBIE_DEPTH > 1) ? $clog2(ZOMBIE_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr,
    input  logic [ZA_W-1:0]    i_wr_addr,
    input  logic [ID_BITS-1:0] i_wr_data,
    input  logic               i_rd,
    input  logic [ZA_W-1:0]    i_rd_addr,
    output logic [ID_BITS-1:0] o_rd_data
);

    logic [ID_BITS-1:0] r_mem [ZOMBIE_DEPTH];
    logic [ID_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/fcfs_run_queue_with_steal.sv -----
`timescale 1ns / 1ps

// FCFS run queue with work stealing. The run queue is a row of RUN_DEPTH
// cells, head at cell 0, each holding one thread descriptor captured at
// enqueue; dying threads go to a separate zombie store of ZOMBIE_DEPTH ids.
// One command is handled at a time. Enqueue, and an unknown mode, pass
// MATCH and then EMIT, which loads the output register. Remove, fetch and
// steal add FIRST and APPLY after MATCH: every cell compares in parallel, a
// one-bit ripple through the cell row picks the first match (oldest for
// remove and fetch, nearest the tail per preference level for steal), and
// the cells past the pick then shift one place toward the head. Tick reads
// the zombie store one id at a time through its registered port, emits
// each zombie id and ends with a final reschedule result. Every result
// reports the run-queue count after the command; a full queue drops the
// enqueue and flags overflow, as does a full zombie store for a dying
// thread. The input side stays ready while a finished result waits at the
// output register, and output stalls hold the block in its current step.
module fcfs_run_queue_with_steal #(
    parameter int RUN_DEPTH    = fcfsrq_pkg::RUN_DEPTH_DEF,
    parameter int ZOMBIE_DEPTH = fcfsrq_pkg::ZOMBIE_DEPTH_DEF,
    parameter int CPU_BITS     = fcfsrq_pkg::CPU_BITS_DEF,
    parameter int ID_BITS      = fcfsrq_pkg::ID_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fcfsrq_pkg::MODE_W-1:0]   i_mode,
    input  logic [ID_BITS-1:0]              i_thread_id,
    input  logic                            i_dying,
    input  logic                            i_ready_req,
    input  logic                            i_idle_thread,
    input  logic                            i_init_thread,
    input  logic [CPU_BITS-1:0]             i_affinity_cpu,
    input  logic                            i_affinity_hard,
    input  logic [CPU_BITS-1:0]             i_thief_cpu,
    input  logic [ID_BITS-1:0]              i_current_thread,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fcfsrq_pkg::KIND_W-1:0]   o_kind,
    output logic [fcfsrq_pkg::OUT_ID_W-1:0] o_out_thread,
    output logic                            o_last,
    output logic [fcfsrq_pkg::QCNT_W-1:0]   o_queue_count,
    output logic                            o_overflow
);

    localparam int DESC_W = ID_BITS + CPU_BITS + fcfsrq_pkg::DESC_FLAG_W;
    localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
    localparam int ZC_W   = $clog2(ZOMBIE_DEPTH + 1);
    localparam int ZA_W   = (ZOMBIE_DEPTH > 1) ? $clog2(ZOMBIE_DEPTH) : 1;

    // Control state
    fcfsrq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ZC_W-1:0]    r_zcount, n_zcount;
    logic [ZC_W-1:0]    r_zidx, n_zidx;
    logic               r_out_valid;

    // Command held for the duration of its work
    fcfsrq_pkg::t_mode  r_mode;
    logic [ID_BITS-1:0] r_tid;
    logic               r_dying;
    logic [DESC_W-1:0]  r_new_desc;
    logic [CPU_BITS-1:0] r_stealer;
    logic [ID_BITS-1:0] r_cur;

    // Resolve results from the cell row
    logic [fcfsrq_pkg::UP_W-1:0] r_any_up;
    logic                        r_any_dn;

    // Pending result
    fcfsrq_pkg::t_kind             r_res_kind, n_res_kind;
    logic [fcfsrq_pkg::OUT_ID_W-1:0] r_res_id, n_res_id;
    logic                          r_res_ovf, n_res_ovf;

    // Output register
    fcfsrq_pkg::t_kind               r_kind;
    logic [fcfsrq_pkg::OUT_ID_W-1:0] r_out_id;
    logic                            r_last;
    logic [fcfsrq_pkg::QCNT_W-1:0]   r_qcount;
    logic                            r_ovf;

    // Combinational control
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_out_load;
    fcfsrq_pkg::t_kind               w_out_kind;
    logic [fcfsrq_pkg::OUT_ID_W-1:0] w_out_id;
    logic                            w_out_last;
    logic                            w_out_ovf;
    logic                            w_run_wr;
    logic                            w_zq_wr;
    logic                            w_zq_rd;
    logic [ID_BITS-1:0]              w_zq_data;
    fcfsrq_pkg::t_cell_ctl           w_ctl;
    logic [fcfsrq_pkg::PICK_W-1:0]   w_pick;
    logic                            w_found;
    logic [ID_BITS-1:0]              w_hit;

    // Cell row wiring
    logic [DESC_W-1:0]               w_desc     [RUN_DEPTH];
    logic [DESC_W-1:0]               w_next     [RUN_DEPTH];
    logic [ID_BITS-1:0]              w_hit_cell [RUN_DEPTH];
    logic [fcfsrq_pkg::UP_W-1:0]     w_up_seen  [RUN_DEPTH+1];
    logic                            w_dn_seen  [RUN_DEPTH+1];
    logic                            w_sel_seen [RUN_DEPTH+1];
    logic [RUN_DEPTH-1:0]            w_occ;
    logic [RUN_DEPTH-1:0]            w_wr;
    logic [RUN_DEPTH-1:0]            w_sel;

    assign o_in_ready = (r_state == fcfsrq_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Run-queue cell row. Tail-side chains (steal levels) run from the last
    // cell down to cell 0; head-side chains (remove/fetch pick, shift) run
    // from cell 0 up.
    // ------------------------------------------------------------------
    assign w_up_seen[RUN_DEPTH] = '0;
    assign w_dn_seen[0]         = 1'b0;
    assign w_sel_seen[0]        = 1'b0;

    for (genvar gi = 0; gi < RUN_DEPTH; gi++) begin : g_cell
        assign w_occ[gi] = (CNT_W'(gi) < r_count);
        assign w_wr[gi]  = w_run_wr && (r_count == CNT_W'(gi));
        if (gi == RUN_DEPTH - 1) begin : g_tail
            assign w_next[gi] = '0;
        end else begin : g_body
            assign w_next[gi] = w_desc[gi+1];
        end

        fcfsrq_cell #(
            .ID_BITS  (ID_BITS),
            .CPU_BITS (CPU_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[gi]),
            .i_wr        (w_wr[gi]),
            .i_new_desc  (r_new_desc),
            .i_next_desc (w_next[gi]),
            .i_key_id    (r_tid),
            .i_cur_id    (r_cur),
            .i_cpu       (r_stealer),
            .i_up_seen   (w_up_seen[gi+1]),
            .i_dn_seen   (w_dn_seen[gi]),
            .i_sel_seen  (w_sel_seen[gi]),
            .o_desc      (w_desc[gi]),
            .o_up_seen   (w_up_seen[gi]),
            .o_dn_seen   (w_dn_seen[gi+1]),
            .o_sel_seen  (w_sel_seen[gi+1]),
            .o_sel       (w_sel[gi]),
            .o_hit       (w_hit_cell[gi])
        );
    end

    // At most one cell is picked, so OR the masked ids together
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < RUN_DEPTH; i++) begin
            w_hit = w_hit | w_hit_cell[i];
        end
    end

    // ------------------------------------------------------------------
    // Zombie store
    // ------------------------------------------------------------------
    fcfsrq_zq #(
        .ZOMBIE_DEPTH (ZOMBIE_DEPTH),
        .ID_BITS      (ID_BITS)
    ) u_zq (
        .i_clk     (i_clk),
        .i_wr      (w_zq_wr),
        .i_wr_addr (r_zcount[ZA_W-1:0]),
        .i_wr_data (r_tid),
        .i_rd      (w_zq_rd),
        .i_rd_addr (r_zidx[ZA_W-1:0]),
        .o_rd_data (w_zq_data)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_zcount   = r_zcount;
        n_zidx     = r_zidx;
        n_res_kind = r_res_kind;
        n_res_id   = r_res_id;
        n_res_ovf  = r_res_ovf;
        w_run_wr   = 1'b0;
        w_zq_wr    = 1'b0;
        w_zq_rd    = 1'b0;
        w_out_load = 1'b0;
        w_out_kind = fcfsrq_pkg::KIND_ACK;
        w_out_id   = '0;
        w_out_last = 1'b1;
        w_out_ovf  = 1'b0;
        w_pick     = '0;
        w_found    = 1'b0;
        w_ctl.op    = fcfsrq_pkg::OP_HOLD;
        w_ctl.fetch = (r_mode == fcfsrq_pkg::MODE_FETCH);
        w_ctl.pick  = '0;

        unique case (r_state)
            fcfsrq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fcfsrq_pkg::ST_MATCH;
                end
            end

            fcfsrq_pkg::ST_MATCH: begin
                n_res_kind = fcfsrq_pkg::KIND_ACK;
                n_res_id   = '0;
                n_res_ovf  = 1'b0;
                n_state    = fcfsrq_pkg::ST_EMIT;
                unique case (r_mode)
                    fcfsrq_pkg::MODE_ENQ: begin
                        // Append to the tail, or drop and flag when full
                        if (r_dying) begin
                            if (r_zcount >= ZC_W'(ZOMBIE_DEPTH)) begin
                                n_res_ovf = 1'b1;
                            end else begin
                                w_zq_wr  = 1'b1;
                                n_zcount = r_zcount + ZC_W'(1);
                            end
                        end else begin
                            if (r_count >= CNT_W'(RUN_DEPTH)) begin
                                n_res_ovf = 1'b1;
                            end else begin
                                w_run_wr = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                    end
                    fcfsrq_pkg::MODE_REMOVE,
                    fcfsrq_pkg::MODE_FETCH,
                    fcfsrq_pkg::MODE_STEAL: begin
                        w_ctl.op = fcfsrq_pkg::OP_MATCH;
                        n_state  = fcfsrq_pkg::ST_FIRST;
                    end
                    fcfsrq_pkg::MODE_TICK: begin
                        n_zidx = '0;
                        if (r_zcount == '0) begin
                            n_res_kind = fcfsrq_pkg::KIND_RESCHED;
                        end else begin
                            n_state = fcfsrq_pkg::ST_ZREAD;
                        end
                    end
                    default: begin
                        // Unknown mode: acknowledge only
                    end
                endcase
            end

            fcfsrq_pkg::ST_FIRST: begin
                w_ctl.op = fcfsrq_pkg::OP_FIRST;
                n_state  = fcfsrq_pkg::ST_APPLY;
            end

            fcfsrq_pkg::ST_APPLY: begin
                // Steal prefers a cpu match, then soft, then hard affinity
                if (r_mode == fcfsrq_pkg::MODE_STEAL) begin
                    priority if (r_any_up[fcfsrq_pkg::PICK_L0]) begin
                        w_pick[fcfsrq_pkg::PICK_L0] = 1'b1;
                    end else if (r_any_up[fcfsrq_pkg::PICK_L1]) begin
                        w_pick[fcfsrq_pkg::PICK_L1] = 1'b1;
                    end else if (r_any_up[fcfsrq_pkg::PICK_L2]) begin
                        w_pick[fcfsrq_pkg::PICK_L2] = 1'b1;
                    end else begin
                        w_pick = '0;
                    end
                end else begin
                    w_pick[fcfsrq_pkg::PICK_DN] = 1'b1;
                end
                w_found    = |(w_pick & {r_any_dn, r_any_up});
                w_ctl.op   = fcfsrq_pkg::OP_SHIFT;
                w_ctl.pick = w_pick;
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end
                if (w_found && r_mode != fcfsrq_pkg::MODE_REMOVE) begin
                    n_res_kind = fcfsrq_pkg::KIND_THREAD;
                    n_res_id   = fcfsrq_pkg::OUT_ID_W'(w_hit);
                end
                n_state = fcfsrq_pkg::ST_EMIT;
            end

            fcfsrq_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_kind = r_res_kind;
                    w_out_id   = r_res_id;
                    w_out_ovf  = r_res_ovf;
                    n_state    = fcfsrq_pkg::ST_IDLE;
                end
            end

            fcfsrq_pkg::ST_ZREAD: begin
                w_zq_rd = 1'b1;
                n_state = fcfsrq_pkg::ST_ZEMIT;
            end

            fcfsrq_pkg::ST_ZEMIT: begin
                // Hold the read data until the output register frees up
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_kind = fcfsrq_pkg::KIND_ZOMBIE;
                    w_out_id   = fcfsrq_pkg::OUT_ID_W'(w_zq_data);
                    w_out_last = 1'b0;
                    n_zidx     = r_zidx + ZC_W'(1);
                    if (n_zidx < r_zcount) begin
                        n_state = fcfsrq_pkg::ST_ZREAD;
                    end else begin
                        n_zcount   = '0;
                        n_res_kind = fcfsrq_pkg::KIND_RESCHED;
                        n_res_id   = '0;
                        n_res_ovf  = 1'b0;
                        n_state    = fcfsrq_pkg::ST_EMIT;
                    end
                end
            end

            default: begin
                n_state = fcfsrq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcfsrq_pkg::ST_IDLE;
            r_count     <= '0;
            r_zcount    <= '0;
            r_zidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_zcount <= n_zcount;
            r_zidx   <= n_zidx;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= fcfsrq_pkg::t_mode'(i_mode);
            r_tid      <= i_thread_id;
            r_dying    <= i_dying;
            r_new_desc <= {i_thread_id, i_affinity_cpu, i_ready_req, i_idle_thread,
                           i_init_thread, i_affinity_hard};
            r_stealer  <= i_thief_cpu;
            r_cur      <= i_current_thread;
        end
        if (r_state == fcfsrq_pkg::ST_FIRST) begin
            r_any_up <= w_up_seen[0];
            r_any_dn <= w_dn_seen[RUN_DEPTH];
        end
        r_res_kind <= n_res_kind;
        r_res_id   <= n_res_id;
        r_res_ovf  <= n_res_ovf;
        if (w_out_load) begin
            r_kind   <= w_out_kind;
            r_out_id <= w_out_id;
            r_last   <= w_out_last;
            r_qcount <= fcfsrq_pkg::QCNT_W'(n_count);
            r_ovf    <= w_out_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_thread  = r_out_id;
    assign o_last        = r_last;
    assign o_queue_count = r_qcount;
    assign o_overflow    = r_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RUN_DEPTH))
        else $error("run-queue count past depth");

    a_zombie_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zcount <= ZC_W'(ZOMBIE_DEPTH))
        else $error("zombie count past depth");

    a_single_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcfsrq_pkg::ST_APPLY) |-> $onehot0(w_sel))
        else $error("more than one cell picked");

    a_pick_matches_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcfsrq_pkg::ST_APPLY) |-> (w_sel_seen[RUN_DEPTH] == w_found))
        else $error("cell pick disagrees with resolve flags");

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcfsrq_pkg::ST_ZEMIT) |-> (r_zidx < r_zcount))
        else $error("zombie drain pointer past fill");

endmodule
